@@ rtl/core/worst_fit_segment_allocator_defines.svh @@
// Assertion macros for the worst-fit allocator.
`ifndef WORST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define WORST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WFSA_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define WFSA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define WFSA_ASSERT(lbl, ck, rn, prop, msg)
`define WFSA_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

@@ rtl/core/wfsa_pkg.sv @@
`default_nettype none
package wfsa_pkg;
	localparam int CELL_W = 31;
	localparam int TGT_W = 10;
	localparam logic [CELL_W-1:0] SPACE_RESET = 31'd1048576;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef struct packed {
		logic              op;
		logic [CELL_W-1:0] size;
		logic [TGT_W-1:0]  free_target;
	} item_t;

	typedef struct packed {
		logic              granted;
		logic [CELL_W-1:0] position;
	} result_t;

	// one RAM word: a free segment or a recorded grant
	typedef struct packed {
		logic [CELL_W-1:0] start;
		logic [CELL_W-1:0] len;
		logic              live;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);

	typedef struct packed {
		logic clr_wr;
		logic latch;
		logic grant_rd;
		logic gchk;
		logic scan_rd;
		logic act;
		logic rinv;
	} cmd_t;

	typedef struct packed {
		logic target_ok;
		logic merge_both;
	} stat_t;
endpackage
`default_nettype wire

@@ rtl/core/worst_fit_segment_allocator.sv @@
// channel   | signals                                    | handshake
// ----------+--------------------------------------------+-------------------------------
// item      | start, busy, cmd (op, size, free_target)  | taken when start && !busy
// result    | done, result (granted, position)           | one-cycle strobe, no stall
// config    | psel penable pwrite paddr pwdata prdata    | APB, written in access phase
//
// After reset, and after every space_size write, a clear sweep over max(FREE_SLOTS,
// MAX_REQUESTS) entries rebuilds the free table and drops all grants; busy is high.
// Allocate: a scan of the free table, one entry per cycle, then the update. Free: a grant
// read and check, the same scan, the update and, when both neighbors merge, one more write;
// an empty target returns after the check. done is registered from an allocate update only.
`default_nettype none
module worst_fit_segment_allocator #(
	parameter int MAX_REQUESTS = 1024,
	parameter int FREE_SLOTS = 1025
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire wfsa_pkg::item_t   cmd,
	output logic                   done,
	output wfsa_pkg::result_t      result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [1:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	localparam int CLR_LEN = (FREE_SLOTS > MAX_REQUESTS) ? FREE_SLOTS : MAX_REQUESTS;
	localparam int IW = $clog2(CLR_LEN);

	wfsa_pkg::cmd_t c_cmd;
	wfsa_pkg::stat_t c_st;
	logic [IW-1:0] idx;
	logic cfg_wr;
	logic [wfsa_pkg::CELL_W-1:0] space;

	// single register at offset zero
	assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
	assign pready = 1'b1;
	assign prdata = {1'b0, space};

	wfsa_ctrl #(.MAX_REQUESTS(MAX_REQUESTS), .FREE_SLOTS(FREE_SLOTS)) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op_in (cmd.op),
		.cfg_wr(cfg_wr),
		.st    (c_st),
		.cmd   (c_cmd),
		.idx   (idx),
		.busy  (busy)
	);

	wfsa_dp #(.MAX_REQUESTS(MAX_REQUESTS), .FREE_SLOTS(FREE_SLOTS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (c_cmd),
		.idx     (idx),
		.item    (cmd),
		.cfg_wr  (cfg_wr),
		.cfg_data(pwdata[wfsa_pkg::CELL_W-1:0]),
		.space   (space),
		.st      (c_st),
		.done    (done),
		.result  (result)
	);
endmodule
`default_nettype wire

@@ rtl/core/wfsa_ram.sv @@
`default_nettype none
module wfsa_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/wfsa_ctrl.sv @@
`default_nettype none
`include "worst_fit_segment_allocator_defines.svh"
module wfsa_ctrl #(
	parameter int MAX_REQUESTS = 1024,
	parameter int FREE_SLOTS = 1025,
	localparam int CLR_LEN = (FREE_SLOTS > MAX_REQUESTS) ? FREE_SLOTS : MAX_REQUESTS,
	localparam int IW = $clog2(CLR_LEN)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           op_in,
	input  wire logic           cfg_wr,
	input  wire wfsa_pkg::stat_t st,
	output wfsa_pkg::cmd_t      cmd,
	output logic [IW-1:0]       idx,
	output logic                busy
);
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_GRD  = 3'd2;
	localparam logic [2:0] ST_GCHK = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_LAST = 3'd5;
	localparam logic [2:0] ST_ACT  = 3'd6;
	localparam logic [2:0] ST_RINV = 3'd7;

	logic [2:0] state_q;
	logic [IW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			idx_q <= '0;
		end else if (cfg_wr) begin
			state_q <= ST_CLR;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (idx_q == IW'(CLR_LEN - 1)) begin
						state_q <= ST_IDLE;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						state_q <= (op_in == wfsa_pkg::OP_ALLOC) ? ST_SCAN : ST_GRD;
					end
				end
				ST_GRD: state_q <= ST_GCHK;
				ST_GCHK: begin
					idx_q <= '0;
					state_q <= st.target_ok ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (idx_q == IW'(FREE_SLOTS - 1)) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LAST: state_q <= ST_ACT;
				ST_ACT: state_q <= st.merge_both ? ST_RINV : ST_IDLE;
				ST_RINV: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.clr_wr = (state_q == ST_CLR);
		cmd.latch = (state_q == ST_IDLE) && start;
		cmd.grant_rd = (state_q == ST_GRD);
		cmd.gchk = (state_q == ST_GCHK);
		cmd.scan_rd = (state_q == ST_SCAN);
		cmd.act = (state_q == ST_ACT);
		cmd.rinv = (state_q == ST_RINV);
	end

	assign idx = idx_q;
	assign busy = (state_q != ST_IDLE);

	`WFSA_ASSERT(a_cfg_clears, clk, arst_n, cfg_wr |=> state_q == ST_CLR, "config write must restart clear")
	`WFSA_ASSERT(a_act_once, clk, arst_n, (state_q == ST_ACT) && !cfg_wr |=> state_q != ST_ACT, "update state held")
	`WFSA_ASSERT(a_scan_end, clk, arst_n, (state_q == ST_LAST) && !cfg_wr |=> state_q == ST_ACT, "scan tail lost")
endmodule
`default_nettype wire

@@ rtl/core/wfsa_dp.sv @@
`default_nettype none
`include "worst_fit_segment_allocator_defines.svh"
module wfsa_dp #(
	parameter int MAX_REQUESTS = 1024,
	parameter int FREE_SLOTS = 1025,
	localparam int CLR_LEN = (FREE_SLOTS > MAX_REQUESTS) ? FREE_SLOTS : MAX_REQUESTS,
	localparam int IW = $clog2(CLR_LEN),
	localparam int FW = $clog2(FREE_SLOTS),
	localparam int AW = $clog2(MAX_REQUESTS),
	localparam int CNTW = $clog2(MAX_REQUESTS + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire wfsa_pkg::cmd_t                   cmd,
	input  wire logic [IW-1:0]                    idx,
	input  wire wfsa_pkg::item_t                  item,
	input  wire logic                             cfg_wr,
	input  wire logic [wfsa_pkg::CELL_W-1:0]      cfg_data,
	output logic [wfsa_pkg::CELL_W-1:0]           space,
	output wfsa_pkg::stat_t                       st,
	output logic                                  done,
	output wfsa_pkg::result_t                     result
);
	localparam int CW = wfsa_pkg::CELL_W;

	logic [CW-1:0] space_q;
	logic [CNTW-1:0] count_q;

	// latched item
	logic op_q;
	logic [CW-1:0] size_q;
	logic [31:0] tgt_q;
	logic [CNTW-1:0] req_q;
	logic req_ok_q;

	// grant record of the target
	logic tok_q;
	logic [CW-1:0] gs_q, gl_q;
	logic [CW:0] gend_q;

	// scan trackers
	logic rd_vld_s1;
	logic [FW-1:0] idx_s1;
	logic best_f_q, left_f_q, right_f_q, empty_f_q;
	logic [FW-1:0] best_i_q, left_i_q, right_i_q, empty_i_q;
	logic [CW-1:0] best_s_q, best_l_q, left_s_q, left_l_q, right_l_q;

	logic done_q;
	wfsa_pkg::result_t result_q;

	wfsa_pkg::seg_t fr_rd, fr_wd, gr_rd, gr_wd;
	logic fr_we, gr_we;
	logic [FW-1:0] fr_wa;
	logic [AW-1:0] gr_wa;
	logic tgt_in_rng;
	logic alloc_ok;
	logic [31:0] idx_ext;

	assign idx_ext = 32'(idx);
	assign tgt_in_rng = tgt_q < 32'(MAX_REQUESTS);
	assign alloc_ok = req_ok_q && (size_q != '0) && best_f_q && (best_l_q >= size_q);

	wfsa_ram #(.W(wfsa_pkg::SEG_W), .DEPTH(FREE_SLOTS)) u_free_ram (
		.clk  (clk),
		.we   (fr_we),
		.waddr(fr_wa),
		.wdata(fr_wd),
		.raddr(idx[FW-1:0]),
		.rdata(fr_rd)
	);

	wfsa_ram #(.W(wfsa_pkg::SEG_W), .DEPTH(MAX_REQUESTS)) u_grant_ram (
		.clk  (clk),
		.we   (gr_we),
		.waddr(gr_wa),
		.wdata(gr_wd),
		.raddr(tgt_q[AW-1:0]),
		.rdata(gr_rd)
	);

	// write port steering
	always_comb begin
		fr_we = 1'b0;
		fr_wa = '0;
		fr_wd = '0;
		gr_we = 1'b0;
		gr_wa = '0;
		gr_wd = '0;
		if (cmd.clr_wr) begin
			fr_we = idx_ext < 32'(FREE_SLOTS);
			fr_wa = idx[FW-1:0];
			if (idx == '0) begin
				fr_wd.len = space_q;
				fr_wd.live = (space_q != '0);
			end
			gr_we = idx_ext < 32'(MAX_REQUESTS);
			gr_wa = idx[AW-1:0];
		end else if (cmd.act && (op_q == wfsa_pkg::OP_ALLOC)) begin
			fr_we = alloc_ok;
			fr_wa = best_i_q;
			fr_wd.start = best_s_q + size_q;
			fr_wd.len = best_l_q - size_q;
			fr_wd.live = (best_l_q != size_q);
			gr_we = alloc_ok;
			gr_wa = req_q[AW-1:0];
			gr_wd.start = best_s_q;
			gr_wd.len = size_q;
			gr_wd.live = 1'b1;
		end else if (cmd.act) begin
			fr_we = tok_q && (left_f_q || right_f_q || empty_f_q);
			fr_wa = left_f_q ? left_i_q : (right_f_q ? right_i_q : empty_i_q);
			fr_wd.start = left_f_q ? left_s_q : gs_q;
			fr_wd.len = gl_q + (left_f_q ? left_l_q : '0) + (right_f_q ? right_l_q : '0);
			fr_wd.live = 1'b1;
			gr_we = fr_we;
			gr_wa = tgt_q[AW-1:0];
			gr_wd.start = gs_q;
			gr_wd.len = gl_q;
			gr_wd.live = 1'b0;
		end else if (cmd.rinv) begin
			fr_we = 1'b1;
			fr_wa = right_i_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q <= wfsa_pkg::SPACE_RESET;
			count_q <= '0;
			done_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			tok_q <= 1'b0;
			best_f_q <= 1'b0;
			left_f_q <= 1'b0;
			right_f_q <= 1'b0;
			empty_f_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				space_q <= cfg_data;
			end
			done_q <= cmd.act && (op_q == wfsa_pkg::OP_ALLOC);
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.latch) begin
				if (count_q < CNTW'(MAX_REQUESTS)) begin
					count_q <= count_q + 1'b1;
				end
				tok_q <= 1'b0;
				best_f_q <= 1'b0;
				left_f_q <= 1'b0;
				right_f_q <= 1'b0;
				empty_f_q <= 1'b0;
			end
			if (cmd.gchk) begin
				tok_q <= tgt_in_rng && gr_rd.live;
			end
			if (rd_vld_s1) begin
				if (op_q == wfsa_pkg::OP_ALLOC) begin
					if (fr_rd.live && (!best_f_q || (fr_rd.len > best_l_q) ||
						((fr_rd.len == best_l_q) && (fr_rd.start < best_s_q)))) begin
						best_f_q <= 1'b1;
					end
				end else if (fr_rd.live) begin
					if (({1'b0, fr_rd.start} + {1'b0, fr_rd.len}) == {1'b0, gs_q}) begin
						left_f_q <= 1'b1;
					end else if ({1'b0, fr_rd.start} == gend_q) begin
						right_f_q <= 1'b1;
					end
				end else begin
					empty_f_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= item.op;
			size_q <= item.size;
			tgt_q <= 32'(item.free_target);
			req_q <= count_q;
			req_ok_q <= count_q < CNTW'(MAX_REQUESTS);
		end
		if (cmd.gchk) begin
			gs_q <= gr_rd.start;
			gl_q <= gr_rd.len;
			gend_q <= {1'b0, gr_rd.start} + {1'b0, gr_rd.len};
		end
		idx_s1 <= idx[FW-1:0];
		if (rd_vld_s1) begin
			if (op_q == wfsa_pkg::OP_ALLOC) begin
				if (fr_rd.live && (!best_f_q || (fr_rd.len > best_l_q) ||
					((fr_rd.len == best_l_q) && (fr_rd.start < best_s_q)))) begin
					best_i_q <= idx_s1;
					best_s_q <= fr_rd.start;
					best_l_q <= fr_rd.len;
				end
			end else if (fr_rd.live) begin
				if (({1'b0, fr_rd.start} + {1'b0, fr_rd.len}) == {1'b0, gs_q}) begin
					left_i_q <= idx_s1;
					left_s_q <= fr_rd.start;
					left_l_q <= fr_rd.len;
				end else if ({1'b0, fr_rd.start} == gend_q) begin
					right_i_q <= idx_s1;
					right_l_q <= fr_rd.len;
				end
			end else if (!empty_f_q) begin
				empty_i_q <= idx_s1;
			end
		end
		if (cmd.act && (op_q == wfsa_pkg::OP_ALLOC)) begin
			result_q.granted <= alloc_ok;
			result_q.position <= alloc_ok ? (best_s_q + 1'b1) : '0;
		end
	end

	assign st.target_ok = tgt_in_rng && gr_rd.live;
	assign st.merge_both = (op_q == wfsa_pkg::OP_FREE) && tok_q && left_f_q && right_f_q;
	assign space = space_q;
	assign done = done_q;
	assign result = result_q;

	`WFSA_ASSERT(a_done_alloc, clk, arst_n, done |-> op_q == wfsa_pkg::OP_ALLOC, "result from a free")
	`WFSA_ASSERT(a_refused_zero, clk, arst_n, done && !result.granted |-> result.position == '0, "refusal with position")
	`WFSA_ASSERT(a_done_single, clk, arst_n, done |=> !done, "result repeated")
endmodule
`default_nettype wire

@@ test/tb_worst_fit_segment_allocator.sv @@
`default_nettype none
module tb_worst_fit_segment_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import wfsa_pkg::*;

	localparam int MAX_REQ = 1024;
	localparam int SLOTS = 1025;
	localparam int SETTLE = 1200;

	class alloc_scoreboard;
		bit [CELL_W-1:0] space;
		bit [CELL_W-1:0] seg_start[SLOTS];
		bit [CELL_W-1:0] seg_len[SLOTS];
		bit              seg_valid[SLOTS];
		bit [CELL_W-1:0] held_start[MAX_REQ];
		bit [CELL_W-1:0] held_len[MAX_REQ];
		bit              held_live[MAX_REQ];
		int unsigned     req_count;
		result_t         grants_due[$];
		int              errors;

		function void rebuild();
			foreach (seg_valid[i]) seg_valid[i] = 0;
			foreach (held_live[i]) held_live[i] = 0;
			seg_start[0] = 0;
			seg_len[0] = space;
			seg_valid[0] = (space != 0);
		endfunction

		function void reset_state();
			space = SPACE_RESET;
			req_count = 0;
			errors = 0;
			rebuild();
		endfunction

		function void write_size(bit [31:0] v);
			space = v[CELL_W-1:0];
			rebuild();
		endfunction

		function void report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endfunction

		function void allocate(bit [CELL_W-1:0] sz);
			int best;
			result_t r;
			best = -1;
			r = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (!seg_valid[i]) continue;
				if (best < 0 || seg_len[i] > seg_len[best] ||
				    (seg_len[i] == seg_len[best] && seg_start[i] < seg_start[best]))
					best = i;
			end
			if (!(req_count >= MAX_REQ || sz == 0 || best < 0 || seg_len[best] < sz)) begin
				held_start[req_count] = seg_start[best];
				held_len[req_count] = sz;
				held_live[req_count] = 1;
				r.granted = 1;
				r.position = seg_start[best] + 1'b1;
				if (seg_len[best] == sz) seg_valid[best] = 0;
				else begin
					seg_start[best] += sz;
					seg_len[best] -= sz;
				end
			end
			grants_due.push_back(r);
		endfunction

		function void release_block(int tgt);
			bit [31:0] s, len;
			int lft, rgt, slot;
			lft = -1;
			rgt = -1;
			slot = -1;
			if (tgt >= MAX_REQ || !held_live[tgt]) return;
			s = held_start[tgt];
			len = held_len[tgt];
			for (int i = 0; i < SLOTS; i++) begin
				if (!seg_valid[i]) continue;
				if ({1'b0, seg_start[i]} + seg_len[i] == s) lft = i;
				else if ({1'b0, seg_start[i]} == s + len) rgt = i;
			end
			if (lft >= 0) begin
				s = seg_start[lft];
				len += seg_len[lft];
				slot = lft;
			end
			if (rgt >= 0) begin
				len += seg_len[rgt];
				if (slot < 0) slot = rgt;
				else seg_valid[rgt] = 0;
			end
			if (slot < 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (!seg_valid[i]) begin
						slot = i;
						break;
					end
				if (slot < 0) return;
			end
			seg_start[slot] = s[CELL_W-1:0];
			seg_len[slot] = len[CELL_W-1:0];
			seg_valid[slot] = 1;
			held_live[tgt] = 0;
		endfunction

		function void note(item_t it);
			if (it.op == OP_ALLOC) allocate(it.size);
			else release_block(it.free_target);
			if (req_count < MAX_REQ) req_count++;
		endfunction

		function void check(result_t r);
			result_t e;
			if (grants_due.size() == 0) begin
				report($sformatf("unexpected result g=%0b pos=%0d", r.granted, r.position));
				return;
			end
			e = grants_due.pop_front();
			if (r.granted !== e.granted)
				report($sformatf("granted %0b, want %0b", r.granted, e.granted));
			if (r.position !== e.position)
				report($sformatf("position %0d, want %0d", r.position, e.position));
		endfunction

		function int pick_live();
			int t;
			for (int k = 0; k < 30; k++) begin
				t = $urandom_range(MAX_REQ - 1);
				if (held_live[t]) return t;
			end
			for (int i = 0; i < MAX_REQ; i++)
				if (held_live[i]) return i;
			return -1;
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	item_t cmd;
	result_t result;
	logic psel, penable, pwrite, pready;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;

	alloc_scoreboard sb;
	int unsigned sent;
	int idle_pct;

	worst_fit_segment_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note(cmd);
			if (done) sb.check(result);
		end
	end

	task automatic send(item_t it);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 0;
		end
		@(negedge clk);
		start = 1;
		cmd = it;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic alloc(int unsigned sz, output int id);
		item_t it;
		it.op = OP_ALLOC;
		it.size = sz[CELL_W-1:0];
		it.free_target = $urandom;
		id = sent;
		send(it);
	endtask

	task automatic dealloc(int unsigned tgt);
		item_t it;
		it.op = OP_FREE;
		it.size = $urandom;
		it.free_target = tgt[TGT_W-1:0];
		send(it);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 0;
		while (sb.grants_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic set_space(int unsigned v);
		drain();
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		paddr = 0;
		pwdata = v;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		sb.write_size(v);
	endtask

	function automatic int unsigned rand_size();
		int unsigned cap;
		cap = (sb.space == 0) ? 8 : sb.space / 6 + 1;
		case ($urandom_range(19))
			0: return 0;
			1: return $urandom & 32'h7fffffff;
			2: return 32'h7fffffff;
			3: return sb.space;
			default: return $urandom_range(cap, 1);
		endcase
	endfunction

	int unsigned spaces[9] = '{1048576, 30, 1, 2147483647, 1000, 0, 5000, 37, 64};
	int a, b, c, d, t;

	initial begin
		sb = new();
		sb.reset_state();
		sent = 0;
		idle_pct = 0;
		start = 0;
		cmd = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: size extremes, refusals, free of nothing
		alloc(0, a);
		alloc(32'h7fffffff, a);
		alloc(100, a);
		alloc(200, b);
		dealloc(a);
		dealloc(a);
		dealloc(1023);
		alloc(100, c);
		dealloc(b);
		dealloc(c);
		// empty free table
		set_space(0);
		alloc(5, a);
		// whole 31-bit space in one beat
		set_space(32'h7fffffff);
		alloc(32'h7fffffff, a);
		alloc(1, b);
		dealloc(a);
		alloc(1, b);
		// coalescing: right, then left
		set_space(30);
		alloc(10, a);
		alloc(10, b);
		alloc(10, c);
		dealloc(b);
		dealloc(a);
		dealloc(c);
		alloc(30, d);

		for (int ph = 0; ph < 9; ph++) begin
			set_space(spaces[ph]);
			idle_pct = (ph % 4 == 1) ? 69 : (ph % 4 == 3) ? 17 : 0;
			for (int n = 0; n < 58; n++) begin
				t = $urandom_range(99);
				if (t < 55) alloc(rand_size(), a);
				else if (t < 90 && sb.pick_live() >= 0) dealloc(sb.pick_live());
				else dealloc($urandom_range(MAX_REQ - 1));
			end
		end

		// a few allocates right after a size change
		idle_pct = 0;
		set_space(2000);
		for (int n = 0; n < 6; n++) alloc($urandom_range(100, 1), a);

		drain();
		if (sb.grants_due.size() != 0) sb.report("expected results never arrived");
		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
